// File: hdl/pjw_pkg.sv
// Shared constants, types and the per-byte hash step for the PJW bucket hash.
package pjw_pkg;

  localparam int ACC_W  = 32;
  localparam int BYTE_W = 8;
  localparam int SIZE_W = 16;

  localparam logic [ACC_W-1:0] TOP_MASK   = 32'hf000_0000;
  localparam int               FOLD_SHIFT = 24;
  localparam int               STEP_SHIFT = 4;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 16'd53;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam logic [FIFO_CW-1:0] FIFO_FULL = FIFO_CW'(FIFO_DEPTH);

  localparam int CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

  typedef struct packed {
    logic             vld;
    logic [ACC_W-1:0] hash;
  } hash_push_t;

  typedef struct packed {
    logic             not_empty;
    logic [ACC_W-1:0] hash;
  } hash_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } back_state_t;

  function automatic logic [ACC_W-1:0] absorb(input logic [ACC_W-1:0] acc,
                                              input logic [BYTE_W-1:0] b);
    logic [ACC_W-1:0] ext;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] top;
    ext = {{(ACC_W-BYTE_W){b[BYTE_W-1]}}, b};
    sum = (acc << STEP_SHIFT) + ext;
    top = sum & TOP_MASK;
    // fold the top nibble down, then clear it; a no-op when the nibble is zero
    return sum ^ (top >> FOLD_SHIFT) ^ top;
  endfunction

endpackage

// File: hdl/pjw_key_if.sv
// Key byte channel: valid/ready with one byte and an end-of-key flag.
interface pjw_key_if;
  logic                        valid;
  logic                        ready;
  logic [pjw_pkg::BYTE_W-1:0]  key_byte;
  logic                        is_last;

  modport source(output valid, output key_byte, output is_last, input ready);
  modport sink(input valid, input key_byte, input is_last, output ready);
endinterface

// File: hdl/pjw_bucket_if.sv
// Bucket result channel: valid/ready with one bucket index.
interface pjw_bucket_if;
  logic                        valid;
  logic                        ready;
  logic [pjw_pkg::SIZE_W-1:0]  bucket;

  modport source(output valid, output bucket, input ready);
  modport sink(input valid, input bucket, output ready);
endinterface

// File: hdl/pjw_front.sv
// Front end: absorbs key bytes into the accumulator and queues finished hashes.
module pjw_front (
  input  logic                 clk,
  input  logic                 rst,
  pjw_key_if.sink              keys,
  input  logic                 queue_full,
  output pjw_pkg::hash_push_t  push
);

  logic [pjw_pkg::ACC_W-1:0] acc;
  logic [pjw_pkg::ACC_W-1:0] acc_upd;
  logic                      xfer;

  assign keys.ready = !queue_full;
  assign xfer       = keys.valid && keys.ready;
  assign acc_upd    = pjw_pkg::absorb(acc, keys.key_byte);

  assign push.vld  = xfer && keys.is_last;
  assign push.hash = acc_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (xfer) begin
      // start the next key from zero once the last byte is queued
      acc <= keys.is_last ? '0 : acc_upd;
    end
  end

endmodule

// File: hdl/pjw_fifo.sv
// Short queue of finished key hashes between front and back.
module pjw_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  pjw_pkg::hash_push_t  push,
  input  logic                 pop,
  output logic                 full,
  output pjw_pkg::hash_head_t  head
);

  logic [pjw_pkg::ACC_W-1:0]   mem [pjw_pkg::FIFO_DEPTH];
  logic [pjw_pkg::FIFO_AW-1:0] wr_ptr;
  logic [pjw_pkg::FIFO_AW-1:0] rd_ptr;
  logic [pjw_pkg::FIFO_CW-1:0] count;
  logic                        do_pop;

  assign full           = (count == pjw_pkg::FIFO_FULL);
  assign head.not_empty = (count != '0);
  assign head.hash      = mem[rd_ptr];
  assign do_pop         = pop && head.not_empty;

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem[wr_ptr] <= push.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.vld) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push.vld, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/pjw_back.sv
// Back end: bit-serial remainder of the hash by the table size, output register.
module pjw_back (
  input  logic                       clk,
  input  logic                       rst,
  input  pjw_pkg::hash_head_t        head,
  output logic                       pop,
  input  logic [pjw_pkg::SIZE_W-1:0] table_size,
  pjw_bucket_if.source               buckets
);

  pjw_pkg::back_state_t state;
  pjw_pkg::back_state_t state_next;

  logic [pjw_pkg::ACC_W-1:0]  dividend;
  logic [pjw_pkg::SIZE_W-1:0] rem;
  logic [pjw_pkg::SIZE_W-1:0] rem_next;
  logic [pjw_pkg::CNT_W-1:0]  count;
  logic [pjw_pkg::SIZE_W:0]   trial;
  logic [pjw_pkg::SIZE_W:0]   trial_diff;
  logic                       out_valid;
  logic [pjw_pkg::SIZE_W-1:0] out_bucket;
  logic                       load_out;
  logic                       out_free;

  assign out_free   = !out_valid || buckets.ready;
  assign trial      = {rem, dividend[pjw_pkg::ACC_W-1]};
  assign trial_diff = trial - {1'b0, table_size};
  // remainder stays below the divisor, so one compare and subtract per bit
  assign rem_next   = (trial >= {1'b0, table_size}) ? trial_diff[pjw_pkg::SIZE_W-1:0]
                                                    : trial[pjw_pkg::SIZE_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      pjw_pkg::ST_IDLE: if (head.not_empty)              state_next = pjw_pkg::ST_RUN;
      pjw_pkg::ST_RUN:  if (count == pjw_pkg::DIV_LAST)  state_next = pjw_pkg::ST_HOLD;
      pjw_pkg::ST_HOLD: if (out_free)                    state_next = pjw_pkg::ST_IDLE;
      default:          state_next = pjw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (state)
      pjw_pkg::ST_IDLE: pop      = head.not_empty;
      pjw_pkg::ST_HOLD: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pjw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dividend <= head.hash;
      rem      <= '0;
      count    <= '0;
    end else if (state == pjw_pkg::ST_RUN) begin
      dividend <= dividend << 1;
      rem      <= rem_next;
      count    <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      // a zero table size gives bucket zero
      out_bucket <= (table_size == '0) ? '0 : rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (buckets.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign buckets.valid  = out_valid;
  assign buckets.bucket = out_bucket;

endmodule

// File: hdl/pjw_string_hash_bucket.sv
// Top level: key bytes in, hashed into a queue, reduced modulo table size, bucket out.
// Bytes are taken one per cycle while the hash queue has room (four keys deep).
// After its last byte a hash is queued, popped into the remainder unit, reduced there
// one bit per cycle over the 32-bit hash, and loaded into the output register once it is free.
// The remainder unit sets the sustained rate: it takes a new key only after the last bucket is loaded.
// Reset clears the accumulator, empties the queue and sets table_size to 53.
module pjw_string_hash_bucket (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pjw_pkg::SIZE_W-1:0]  cfg_wdata,
  pjw_key_if.sink                     keys,
  pjw_bucket_if.source                buckets
);

  logic [pjw_pkg::SIZE_W-1:0] table_size;
  pjw_pkg::hash_push_t        push;
  pjw_pkg::hash_head_t        head;
  logic                       queue_full;
  logic                       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= pjw_pkg::TABLE_SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  pjw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .keys       (keys),
    .queue_full (queue_full),
    .push       (push)
  );

  pjw_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  pjw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .table_size (table_size),
    .buckets    (buckets)
  );

endmodule
